// ----- hdl/i2cme_pkg.sv -----
// ---------------------------------------------------------------------------
// i2cme_pkg
// Shared types, codes and helper functions of the i2c master byte engine.
// ---------------------------------------------------------------------------
package i2cme_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd4;
  localparam logic [5:0]  WRITE_END_STEP    = 6'd28;
  localparam logic [5:0]  READ_END_STEP     = 6'd20;
  localparam logic [5:0]  SHORT_END_STEP    = 6'd2;

  // one tick of input
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tx_byte;
    logic       no_ack_last;
    logic       sda_in;
  } in_t;

  // one tick of result
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive_en;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
    logic       cmd_rejected;
  } res_t;

  function automatic logic [5:0] end_step(input cmd_t kind);
    logic [5:0] e;
    case (kind)
      CMD_WRITE: e = WRITE_END_STEP;
      CMD_READ:  e = READ_END_STEP;
      default:   e = SHORT_END_STEP;
    endcase
    return e;
  endfunction

  // remainder by three for bit steps below 24
  function automatic logic [1:0] bit_phase(input logic [5:0] s);
    logic [5:0] r;
    r = s;
    if (r >= 6'd12) r = r - 6'd12;
    if (r >= 6'd6)  r = r - 6'd6;
    if (r >= 6'd3)  r = r - 6'd3;
    return r[1:0];
  endfunction

endpackage

// ----- hdl/i2cme_if.sv -----
// ---------------------------------------------------------------------------
// i2cme interfaces
// Valid/ready channels for input ticks, result ticks and configuration.
// ---------------------------------------------------------------------------
interface i2cme_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] tx_byte;
  logic       no_ack_last;
  logic       sda_in;

  modport source (output valid, op, tx_byte, no_ack_last, sda_in, input ready);
  modport sink   (input valid, op, tx_byte, no_ack_last, sda_in, output ready);
endinterface

interface i2cme_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       sda_drive_en;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_received;
  logic       cmd_rejected;

  modport source (output valid, scl_out, sda_out, sda_drive_en, busy_res, done_res,
                  rx_byte, ack_received, cmd_rejected, input ready);
  modport sink   (input valid, scl_out, sda_out, sda_drive_en, busy_res, done_res,
                  rx_byte, ack_received, cmd_rejected, output ready);
endinterface

interface i2cme_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] phase_ticks;

  modport source (output valid, phase_ticks, input ready);
  modport sink   (input valid, phase_ticks, output ready);
endinterface

// ----- hdl/i2cme_core.sv -----
// ---------------------------------------------------------------------------
// i2cme_core
// Sequencer state and the per-tick next-state and result logic.
// ---------------------------------------------------------------------------
module i2cme_core
  import i2cme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  in_t         tick,
  input  logic [15:0] phase_ticks,
  output res_t        result
);

  typedef struct packed {
    cmd_t        kind;
    logic [5:0]  step;
    logic [15:0] count;
    logic [7:0]  shreg;
    logic        scl;
    logic        sda;
    logic        drv;
    logic        ack;
    logic        nack;
    logic [7:0]  rx_hold;
  } state_t;

  state_t st, st_next;

  logic        op_valid;
  logic        act;
  cmd_t        act_kind;
  logic [5:0]  act_step;
  logic [15:0] load;
  logic        done;
  logic        rej;

  assign op_valid = (tick.op >= 3'd1) && (tick.op <= 3'd4);
  assign load     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.kind    <= CMD_NONE;
      st.step    <= '0;
      st.count   <= '0;
      st.shreg   <= '0;
      st.scl     <= 1'b1;
      st.sda     <= 1'b1;
      st.drv     <= 1'b1;
      st.ack     <= 1'b0;
      st.nack    <= 1'b0;
      st.rx_hold <= '0;
    end else if (en) begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next  = st;
    done     = 1'b0;
    rej      = 1'b0;
    act      = 1'b0;
    act_kind = st.kind;
    act_step = st.step;

    if (st.kind != CMD_NONE) begin
      rej = op_valid;
      if (st.count > 16'd1) begin
        st_next.count = st.count - 16'd1;
      end else if (st.step >= end_step(st.kind)) begin
        if (st.kind == CMD_READ) st_next.rx_hold = st.shreg;
        st_next.kind  = CMD_NONE;
        st_next.step  = '0;
        st_next.count = '0;
        done          = 1'b1;
      end else begin
        act = 1'b1;
      end
    end else if (op_valid) begin
      act_kind     = cmd_t'(tick.op);
      act_step     = '0;
      act          = 1'b1;
      st_next.kind = act_kind;
      if (act_kind == CMD_WRITE) st_next.shreg = tick.tx_byte;
      if (act_kind == CMD_READ) begin
        st_next.shreg = '0;
        st_next.nack  = tick.no_ack_last;
      end
    end

    if (act) begin
      case (act_kind)
        CMD_START: begin
          if (act_step == 6'd0) st_next.sda = 1'b0;
          else                  st_next.scl = 1'b0;
        end
        CMD_STOP: begin
          if (act_step == 6'd0) st_next.scl = 1'b1;
          else                  st_next.sda = 1'b1;
        end
        CMD_WRITE: begin
          if (act_step < 6'd24) begin
            case (bit_phase(act_step))
              2'd0: st_next.sda = st_next.shreg[7];
              2'd1: st_next.scl = 1'b1;
              default: begin
                st_next.scl   = 1'b0;
                st_next.shreg = {st_next.shreg[6:0], 1'b0};
              end
            endcase
          end else if (act_step == 6'd24) begin
            st_next.drv = 1'b0;
          end else if (act_step == 6'd25) begin
            st_next.scl = 1'b1;
          end else if (act_step == 6'd26) begin
            st_next.ack = ~tick.sda_in;
            st_next.scl = 1'b0;
          end else begin
            st_next.sda = 1'b0;
            st_next.drv = 1'b1;
          end
        end
        default: begin
          // read byte
          if (act_step == 6'd0) begin
            st_next.drv = 1'b0;
          end else if (act_step <= 6'd16) begin
            if (act_step[0]) begin
              st_next.scl = 1'b1;
            end else begin
              st_next.shreg = {st_next.shreg[6:0], tick.sda_in};
              st_next.scl   = 1'b0;
              st_next.sda   = 1'b0;
            end
          end else if (st_next.nack) begin
            if (act_step == 6'd17) begin
              st_next.scl = 1'b1;
            end else if (act_step == 6'd18) begin
              st_next.scl = 1'b0;
              st_next.sda = 1'b0;
            end else begin
              st_next.sda = 1'b0;
              st_next.drv = 1'b1;
            end
          end else begin
            if (act_step == 6'd17) begin
              st_next.sda = 1'b0;
              st_next.drv = 1'b1;
            end else if (act_step == 6'd18) begin
              st_next.scl = 1'b1;
            end else begin
              st_next.scl = 1'b0;
              st_next.sda = 1'b0;
            end
          end
        end
      endcase
      st_next.step  = act_step + 6'd1;
      st_next.count = load;
    end
  end

  always_comb begin
    result.scl_out      = st_next.scl;
    result.sda_out      = st_next.sda;
    result.sda_drive_en = st_next.drv;
    result.busy_res     = (st_next.kind != CMD_NONE);
    result.done_res     = done;
    result.rx_byte      = st_next.rx_hold;
    result.ack_received = st_next.ack;
    result.cmd_rejected = rej;
  end

  // idle engine keeps its step and wait counters cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (st.kind == CMD_NONE) |-> (st.step == 6'd0 && st.count == 16'd0))
    else $error("idle engine with live step or count");

  // a valid command taken while idle starts a sequence
  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    (en && st.kind == CMD_NONE && op_valid) |=> (st.kind != CMD_NONE))
    else $error("command accepted while idle did not start");

  // no tick taken, no sequencer movement
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(st.step) && $stable(st.count) && $stable(st.kind)))
    else $error("sequencer moved without a beat");

endmodule

// ----- hdl/i2cme_unit_top.sv -----
// ---------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// I2C master sequencer: one input beat per bus clock tick, one result beat out.
// ---------------------------------------------------------------------------
// output: result beat is registered, valid the cycle after its beat is accepted
// throughput: one beat per cycle; the result register frees as it is taken,
//   so input ready only drops while a result waits on a stalled sink
// reset (synchronous, rst high): lines high and driven, engine idle,
//   phase_ticks back to 4, result register empty
module i2c_master_byte_engine_unit
  import i2cme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  i2cme_in_if.sink    cmd,
  i2cme_out_if.source res,
  i2cme_cfg_if.sink   cfg
);

  // configuration: always ready; write only while engine is idle (unchecked)
  logic [15:0] phase_ticks;

  // result register and its valid flag
  logic res_valid;
  res_t res_q;
  res_t res_d;

  logic accept;
  in_t  tick;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg.valid) begin
      phase_ticks <= cfg.phase_ticks;
    end
  end

  // take a beat whenever the result slot is empty or being drained
  assign cmd.ready = !res_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign tick.op          = cmd.op;
  assign tick.tx_byte     = cmd.tx_byte;
  assign tick.no_ack_last = cmd.no_ack_last;
  assign tick.sda_in      = cmd.sda_in;

  // sequencer state lives in the core; it steps once per accepted beat
  i2cme_core u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .tick        (tick),
    .phase_ticks (phase_ticks),
    .result      (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res.valid        = res_valid;
  assign res.scl_out      = res_q.scl_out;
  assign res.sda_out      = res_q.sda_out;
  assign res.sda_drive_en = res_q.sda_drive_en;
  assign res.busy_res     = res_q.busy_res;
  assign res.done_res     = res_q.done_res;
  assign res.rx_byte      = res_q.rx_byte;
  assign res.ack_received = res_q.ack_received;
  assign res.cmd_rejected = res_q.cmd_rejected;

  // every accepted beat shows up as a result beat next cycle
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted beat produced no result");

  // the finishing tick already reports the engine as not busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_q.done_res) |-> !res_q.busy_res)
    else $error("done flagged while still busy");

  // a rejected command can only come while a sequence was running
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && res_d.cmd_rejected) |-> (res_d.busy_res || res_d.done_res))
    else $error("rejection outside a running sequence");

endmodule

// ----- tb/sv/tb_i2c_master_byte_engine_unit.sv -----
// ---------------------------------------------------------------------------
// tb_i2c_master_byte_engine_unit
// Self-checking bench for the i2c master byte engine. Every accepted input
// tick runs through a cycle-accurate software copy of the engine. The
// expected line state is queued and compared field by field with each
// result beat. Stimulus is a directed opener and then random command
// sequences at several phase_ticks settings, zero and one among them.
// Both channels idle at random, and there is one long sink stall.
// ---------------------------------------------------------------------------
module tb_i2c_master_byte_engine_unit;
  import i2cme_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int DRAIN_CYCLES   = 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int TIMEOUT_CYCLES = 1_500_000;

  // op codes outside the command set
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // how the bench drives sda_in while a sequence runs
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  logic clk;
  logic rst;

  i2cme_in_if  cmd_bus ();
  i2cme_out_if res_bus ();
  i2cme_cfg_if cfg_bus ();

  i2c_master_byte_engine_unit DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  // ticks waiting for the driver, expected line states waiting for the sink
  in_t  tick_queue[$];
  res_t due_results[$];

  int  ticks_queued    = 0;
  int  error_count     = 0;
  int  src_gap_left    = 0;
  int  sink_stall_left = 0;
  int  cur_pt          = int'(PHASE_TICKS_RESET);
  bit  src_gaps_on     = 1'b0;
  bit  sink_gaps_on    = 1'b0;
  bit  tick_taken      = 1'b0;
  bit  hold_request    = 1'b0;
  bit  sink_held       = 1'b0;

  // software copy of the engine state
  cmd_t        eng_kind;
  logic [5:0]  eng_step;
  logic [15:0] eng_count;
  logic [7:0]  eng_shift;
  logic [7:0]  eng_rx;
  logic        eng_scl;
  logic        eng_sda;
  logic        eng_drv;
  logic        eng_ack;
  logic        eng_nack;
  logic [15:0] eng_phase;

  // ---------------------------------------------------------------------------
  // engine predictor
  // ---------------------------------------------------------------------------

  // step index at which a sequence has run its last action
  function automatic logic [5:0] last_step(input cmd_t kind);
    case (kind)
      CMD_WRITE: return WRITE_END_STEP;
      CMD_READ:  return READ_END_STEP;
      default:   return SHORT_END_STEP;
    endcase
  endfunction

  // zero phase behaves as one tick
  function automatic logic [15:0] reload_count();
    return (eng_phase == 16'd0) ? 16'd1 : eng_phase;
  endfunction

  // one pin action of a sequence
  function automatic void bus_action(input cmd_t kind, input logic [5:0] s,
                                     input logic sda_bit);
    case (kind)
      CMD_START: begin
        if (s == 6'd0) eng_sda = 1'b0;
        else eng_scl = 1'b0;
      end
      CMD_STOP: begin
        if (s == 6'd0) eng_scl = 1'b1;
        else eng_sda = 1'b1;
      end
      CMD_WRITE: begin
        if (s < 6'd24) begin
          case (s % 6'd3)
            6'd0: eng_sda = eng_shift[7];
            6'd1: eng_scl = 1'b1;
            default: begin
              eng_scl   = 1'b0;
              eng_shift = {eng_shift[6:0], 1'b0};
            end
          endcase
        end else if (s == 6'd24) begin
          eng_drv = 1'b0;
        end else if (s == 6'd25) begin
          eng_scl = 1'b1;
        end else if (s == 6'd26) begin
          eng_ack = ~sda_bit;
          eng_scl = 1'b0;
        end else begin
          eng_sda = 1'b0;
          eng_drv = 1'b1;
        end
      end
      default: begin
        // read: release, eight sampled bits, then ack or nack clock
        if (s == 6'd0) begin
          eng_drv = 1'b0;
        end else if (s <= 6'd16) begin
          if (s[0]) begin
            eng_scl = 1'b1;
          end else begin
            eng_shift = {eng_shift[6:0], sda_bit};
            eng_scl   = 1'b0;
            eng_sda   = 1'b0;
          end
        end else if (eng_nack) begin
          if (s == 6'd17) begin
            eng_scl = 1'b1;
          end else if (s == 6'd18) begin
            eng_scl = 1'b0;
            eng_sda = 1'b0;
          end else begin
            eng_sda = 1'b0;
            eng_drv = 1'b1;
          end
        end else begin
          if (s == 6'd17) begin
            eng_sda = 1'b0;
            eng_drv = 1'b1;
          end else if (s == 6'd18) begin
            eng_scl = 1'b1;
          end else begin
            eng_scl = 1'b0;
            eng_sda = 1'b0;
          end
        end
      end
    endcase
  endfunction

  // advance the engine by one input tick, return the line state after it
  function automatic res_t advance_engine(input in_t t);
    res_t r;
    logic is_cmd;
    logic rej;
    logic fin;
    is_cmd = (t.op >= CMD_START) && (t.op <= CMD_READ);
    rej    = 1'b0;
    fin    = 1'b0;
    if (eng_kind != CMD_NONE) begin
      // busy, including the finishing tick: any command is turned away
      if (is_cmd) rej = 1'b1;
      if (eng_count > 16'd1) begin
        eng_count = eng_count - 16'd1;
      end else if (eng_step >= last_step(eng_kind)) begin
        if (eng_kind == CMD_READ) eng_rx = eng_shift;
        eng_kind  = CMD_NONE;
        eng_step  = 6'd0;
        eng_count = 16'd0;
        fin       = 1'b1;
      end else begin
        bus_action(eng_kind, eng_step, t.sda_in);
        eng_step  = eng_step + 6'd1;
        eng_count = reload_count();
      end
    end else if (is_cmd) begin
      // first action happens on the accepting tick
      eng_kind = cmd_t'(t.op);
      if (eng_kind == CMD_WRITE) eng_shift = t.tx_byte;
      if (eng_kind == CMD_READ) begin
        eng_shift = 8'd0;
        eng_nack  = t.no_ack_last;
      end
      bus_action(eng_kind, 6'd0, t.sda_in);
      eng_step  = 6'd1;
      eng_count = reload_count();
    end
    r.scl_out      = eng_scl;
    r.sda_out      = eng_sda;
    r.sda_drive_en = eng_drv;
    r.busy_res     = (eng_kind != CMD_NONE);
    r.done_res     = fin;
    r.rx_byte      = eng_rx;
    r.ack_received = eng_ack;
    r.cmd_rejected = rej;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // random gap length: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic sda_bit(input int mode);
    if (mode == SDA_LOW) return 1'b0;
    if (mode == SDA_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // ticks a command keeps the engine busy, finishing tick included
  function automatic int seq_ticks(input cmd_t op, input int pt);
    return int'(last_step(op)) * ((pt == 0) ? 1 : pt);
  endfunction

  task automatic push_tick(input logic [2:0] op, input logic [7:0] tx, input logic nack,
                           input logic sda);
    in_t t;
    t.op          = op;
    t.tx_byte     = tx;
    t.no_ack_last = nack;
    t.sda_in      = sda;
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  // background ticks; noise percent carry any op, another 5 percent a spare op
  task automatic filler(input int n, input int sda_mode, input int noise);
    int r;
    logic [2:0] op;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < noise) op = 3'($urandom_range(CMD_START, OP_SPARE_HI));
      else if (r < noise + 5) op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else op = CMD_NONE;
      push_tick(op, 8'($urandom), 1'($urandom), sda_bit(sda_mode));
    end
  endtask

  // command tick plus enough ticks to let it finish; slack moves the next one
  task automatic issue(input cmd_t op, input logic [7:0] tx, input logic nack,
                       input int pt, input int sda_mode, input int slack, input int noise);
    push_tick(op, tx, nack, sda_bit(sda_mode));
    filler(seq_ticks(op, pt) + slack, sda_mode, noise);
  endtask

  // mostly well-formed command runs with random content, some noise
  task automatic random_phase(input int n_ticks);
    int goal;
    int r;
    int slack;
    cmd_t op;
    goal = ticks_queued + n_ticks;
    while (ticks_queued < goal) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        op = cmd_t'(3'($urandom_range(CMD_START, CMD_READ)));
        r  = $urandom_range(0, 99);
        if (r < 70) slack = 0;
        else if (r < 90) slack = $urandom_range(1, 3);
        else slack = -1;
        issue(op, 8'($urandom), 1'($urandom), cur_pt, $urandom_range(SDA_LOW, SDA_RAND),
              slack, 3);
      end else begin
        filler($urandom_range(1, 10), SDA_RAND, 40);
      end
    end
  endtask

  // wait until every queued tick is sent and every result has come back
  task automatic drain();
    while (tick_queue.size() != 0 || cmd_bus.valid || due_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one beat on the config channel, only called with the engine drained
  task automatic set_phase(input logic [15:0] v);
    @(negedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.phase_ticks <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    cur_pt = int'(v);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("tb_i2c_master_byte_engine_unit: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // input driver: one tick per beat, held until taken, random gaps after
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : tick_driver
    in_t nxt;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else if (!cmd_bus.valid || tick_taken) begin
      if (src_gap_left > 0) begin
        src_gap_left = src_gap_left - 1;
        cmd_bus.valid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        nxt = tick_queue.pop_front();
        cmd_bus.op          <= nxt.op;
        cmd_bus.tx_byte     <= nxt.tx_byte;
        cmd_bus.no_ack_last <= nxt.no_ack_last;
        cmd_bus.sda_in      <= nxt.sda_in;
        cmd_bus.valid       <= 1'b1;
        // gap, if any, opens once this beat is taken
        if (src_gaps_on && $urandom_range(0, 3) == 0) src_gap_left = gap_len();
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random stalls, and the long hold when requested
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : result_sink
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else if (sink_held) begin
      res_bus.ready <= 1'b0;
    end else if (sink_stall_left > 0) begin
      sink_stall_left = sink_stall_left - 1;
      res_bus.ready <= 1'b0;
    end else if (sink_gaps_on && $urandom_range(0, 3) == 0) begin
      sink_stall_left = gap_len() - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // long hold-off, counted here; the driver keeps offering meanwhile so the
  // result register fills and the input side must stall
  initial begin : sink_hold
    wait (hold_request);
    @(posedge clk);
    sink_held = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_held = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: check result beats first, then predict for the tick taken now
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : line_monitor
    in_t  beat;
    res_t want;
    tick_taken = 1'b0;
    if (rst) begin
      eng_kind  = CMD_NONE;
      eng_step  = 6'd0;
      eng_count = 16'd0;
      eng_shift = 8'd0;
      eng_rx    = 8'd0;
      eng_scl   = 1'b1;
      eng_sda   = 1'b1;
      eng_drv   = 1'b1;
      eng_ack   = 1'b0;
      eng_nack  = 1'b0;
      eng_phase = PHASE_TICKS_RESET;
      due_results.delete();
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (due_results.size() == 0) begin
          $error("result beat with no tick outstanding");
          error_count++;
        end else begin
          want = due_results.pop_front();
          check_field("scl_out", 8'(want.scl_out), 8'(res_bus.scl_out));
          check_field("sda_out", 8'(want.sda_out), 8'(res_bus.sda_out));
          check_field("sda_drive_en", 8'(want.sda_drive_en), 8'(res_bus.sda_drive_en));
          check_field("busy_res", 8'(want.busy_res), 8'(res_bus.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(res_bus.done_res));
          check_field("rx_byte", want.rx_byte, res_bus.rx_byte);
          check_field("ack_received", 8'(want.ack_received), 8'(res_bus.ack_received));
          check_field("cmd_rejected", 8'(want.cmd_rejected), 8'(res_bus.cmd_rejected));
        end
      end
      // config beats only come with nothing in flight
      if (cfg_bus.valid && cfg_bus.ready) eng_phase = cfg_bus.phase_ticks;
      if (cmd_bus.valid && cmd_bus.ready) begin
        beat.op          = cmd_bus.op;
        beat.tx_byte     = cmd_bus.tx_byte;
        beat.no_ack_last = cmd_bus.no_ack_last;
        beat.sda_in      = cmd_bus.sda_in;
        due_results.push_back(advance_engine(beat));
        tick_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int spare;
    cmd_bus.valid       = 1'b0;
    cmd_bus.op          = CMD_NONE;
    cmd_bus.tx_byte     = 8'd0;
    cmd_bus.no_ack_last = 1'b0;
    cmd_bus.sda_in      = 1'b1;
    res_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.phase_ticks = 16'd0;
    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset phase length, no config write yet
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    issue(CMD_START, 8'd0, 1'b0, cur_pt, SDA_RAND, 0, 0);
    issue(CMD_WRITE, 8'($urandom), 1'b0, cur_pt, SDA_RAND, 0, 0);
    issue(CMD_READ, 8'd0, 1'($urandom), cur_pt, SDA_RAND, 0, 0);
    issue(CMD_STOP, 8'd0, 1'b0, cur_pt, SDA_RAND, 0, 0);
    drain();

    // directed opener at the shortest phase
    set_phase(16'd1);
    issue(CMD_START, 8'd0, 1'b0, cur_pt, SDA_RAND, 0, 0);
    issue(CMD_WRITE, 8'hFF, 1'b0, cur_pt, SDA_LOW, 0, 0);   // all ones, acked
    issue(CMD_WRITE, 8'h00, 1'b0, cur_pt, SDA_HIGH, 0, 0);  // all zeros, not acked
    issue(CMD_READ, 8'h00, 1'b0, cur_pt, SDA_HIGH, 0, 0);   // reads ff, sends ack
    issue(CMD_READ, 8'hFF, 1'b1, cur_pt, SDA_LOW, 0, 0);    // reads 00, sends nack
    // spare op codes while idle: ignored, never rejected
    for (spare = int'(OP_SPARE_LO); spare <= int'(OP_SPARE_HI); spare++)
      push_tick(3'(spare), 8'($urandom), 1'($urandom), 1'($urandom));
    // commands thrown at a running write
    issue(CMD_WRITE, 8'hA5, 1'b0, cur_pt, SDA_RAND, 0, 60);
    // stop lands on the finishing tick of a start and is rejected
    issue(CMD_START, 8'd0, 1'b0, cur_pt, SDA_RAND, -1, 0);
    issue(CMD_STOP, 8'd0, 1'b0, cur_pt, SDA_RAND, 0, 0);
    issue(CMD_STOP, 8'd0, 1'b0, cur_pt, SDA_RAND, 0, 0);
    drain();

    // zero phase behaves as one
    set_phase(16'd0);
    random_phase(80);
    drain();

    // long sink hold while the driver keeps offering
    set_phase(16'd2);
    random_phase(160);
    hold_request = 1'b1;
    drain();

    // back-to-back stretch with no idling on either side
    set_phase(16'd3);
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    random_phase(100);
    drain();

    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    set_phase(16'd1);
    random_phase(120);
    drain();

    set_phase(16'($urandom_range(4, 8)));
    random_phase(60);
    drain();

    // long phase: one full start, run without gaps to keep it short
    set_phase(16'd40);
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    issue(CMD_START, 8'd0, 1'b0, cur_pt, SDA_RAND, 0, 1);
    drain();

    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    set_phase(PHASE_TICKS_RESET);
    random_phase(50);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_i2c_master_byte_engine_unit: done, clean");
    end else begin
      $display("tb_i2c_master_byte_engine_unit: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/i2cme_pkg.sv
hdl/i2cme_if.sv
hdl/i2cme_core.sv
hdl/i2cme_unit_top.sv
tb/sv/tb_i2c_master_byte_engine_unit.sv
